FILE: rtl/core/pchp_pkg.sv
// Shared types and constants of the program counter hotspot profiler.
package pchp_pkg;

  localparam int unsigned ADDR_SPACE = 65536;
  localparam int unsigned IDX_W      = $clog2(ADDR_SPACE);
  localparam int unsigned WIN_DEPTH  = 8;
  localparam int unsigned SLOT_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef struct packed {
    logic              func;
    logic [15:0]       pc;
    logic signed [7:0] cost;
  } req_t;

  typedef struct packed {
    logic        revisit;
    logic [31:0] addr_ops;
    logic [31:0] addr_cycles;
    logic [63:0] all_ops;
    logic [63:0] all_cycles;
    logic [63:0] all_revisits;
  } rsp_t;

  // one store entry: per-address counters
  typedef struct packed {
    logic [31:0] ops;
    logic [31:0] cycles;
  } cnt_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;   // clear one store entry
    logic cap;   // capture request word
    logic look;  // read store, probe window
    logic upd;   // update counters, issue result
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // clearing last store entry
  } dp_sts_t;

endpackage

FILE: rtl/core/pchp_ctrl.sv
// Sequencer of the profiler: store clearing, then capture / lookup / update per word.
module pchp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pchp_pkg::dp_sts_t  sts_i,
  output pchp_pkg::ctl_cmd_t cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_UPD   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

FILE: rtl/core/pchp_dpath.sv
// Datapath of the profiler: counter store, recent-address window, totals, result register.
module pchp_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pchp_pkg::ctl_cmd_t cmd_i,
  output pchp_pkg::dp_sts_t  sts_o,
  input  pchp_pkg::req_t     req_i,
  output logic               done_o,
  output pchp_pkg::rsp_t     rsp_o
);

  // counter store, no reset: cleared by the sweep after reset
  pchp_pkg::cnt_t mem [pchp_pkg::ADDR_SPACE];

  logic [pchp_pkg::IDX_W-1:0] clr_cnt_q;
  pchp_pkg::req_t             req_q;
  pchp_pkg::cnt_t             rd_q;
  logic                       hit_q;

  logic [15:0]                recent_q [pchp_pkg::WIN_DEPTH];
  logic [pchp_pkg::SLOT_W-1:0] slot_q;

  logic [63:0] op_tot_q, cyc_tot_q, rev_tot_q;
  logic        done_q;
  pchp_pkg::rsp_t rsp_q;

  logic [pchp_pkg::IDX_W-1:0] idx;
  logic                       rec;
  logic [6:0]                 cost_c;
  logic                       hit_d;
  pchp_pkg::cnt_t             cnt_new;
  logic [63:0]                op_tot_d, cyc_tot_d, rev_tot_d;

  // power-of-two store: index is the low pc bits
  assign idx    = req_q.pc[pchp_pkg::IDX_W-1:0];
  assign rec    = (req_q.func == pchp_pkg::FUNC_RECORD);
  assign cost_c = req_q.cost[7] ? 7'd0 : req_q.cost[6:0];

  assign sts_o.clr_last = (clr_cnt_q == {pchp_pkg::IDX_W{1'b1}});

  always_comb begin
    hit_d = 1'b0;
    for (int i = 0; i < pchp_pkg::WIN_DEPTH; i++) begin
      if (recent_q[i] == req_q.pc) begin
        hit_d = 1'b1;
      end
    end
  end

  always_comb begin
    cnt_new   = rd_q;
    op_tot_d  = op_tot_q;
    cyc_tot_d = cyc_tot_q;
    rev_tot_d = rev_tot_q;
    if (rec) begin
      cnt_new.ops    = rd_q.ops + 32'd1;
      cnt_new.cycles = rd_q.cycles + {25'd0, cost_c};
      op_tot_d       = op_tot_q + 64'd1;
      cyc_tot_d      = cyc_tot_q + {57'd0, cost_c};
      rev_tot_d      = rev_tot_q + {63'd0, hit_q};
    end
  end

  // store: one write port (clear sweep or update), one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem[clr_cnt_q] <= '0;
    end else if (cmd_i.upd && rec) begin
      mem[idx] <= cnt_new;
    end
    if (cmd_i.look) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q <= req_i;
    end
    if (cmd_i.look) begin
      hit_q <= hit_d;
    end
    if (cmd_i.upd) begin
      rsp_q.revisit      <= rec & hit_q;
      rsp_q.addr_ops     <= cnt_new.ops;
      rsp_q.addr_cycles  <= cnt_new.cycles;
      rsp_q.all_ops      <= op_tot_d;
      rsp_q.all_cycles   <= cyc_tot_d;
      rsp_q.all_revisits <= rev_tot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      slot_q    <= '0;
      op_tot_q  <= '0;
      cyc_tot_q <= '0;
      rev_tot_q <= '0;
      done_q    <= 1'b0;
      for (int i = 0; i < pchp_pkg::WIN_DEPTH; i++) begin
        recent_q[i] <= '0;
      end
    end else begin
      done_q <= cmd_i.upd;
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.upd) begin
        op_tot_q  <= op_tot_d;
        cyc_tot_q <= cyc_tot_d;
        rev_tot_q <= rev_tot_d;
        if (rec) begin
          recent_q[slot_q] <= req_q.pc;
          if (slot_q == pchp_pkg::SLOT_W'(pchp_pkg::WIN_DEPTH - 1)) begin
            slot_q <= '0;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: rtl/core/pc_hotspot_profiler_core.sv
// Top level of the program counter hotspot profiler.
//
// Usage:
//  - Request channel: req_i carries one word (func, pc, cost). It is taken
//    at a rising edge with start high and busy low.
//  - func record: bumps the opcode and cycle counters of pc (32-bit, wrap),
//    the 64-bit totals, and checks pc against the last eight recorded pcs.
//    func read: returns the counters of pc and changes nothing.
//  - Result channel: done_o is high for exactly one cycle with the result
//    word on rsp_o; the receiver must take it then, it cannot stall.
//  - Sequence: each word passes capture, store read + window probe and
//    update/write-back; no new word is taken until the last is through.
//    The counter store's registered read sets this sequence.
//  - busy is low again in the cycle the result is shown, so the next word
//    can be started alongside it.
//  - Reset: totals, window (all zero, so pc 0 hits early) and slot pointer
//    clear at once; then a clearing pass zeroes the 65536-entry store, one
//    entry per cycle, with busy high.
module pc_hotspot_profiler_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pchp_pkg::req_t req_i,
  output logic           done_o,
  output pchp_pkg::rsp_t rsp_o
);

  pchp_pkg::ctl_cmd_t cmd;
  pchp_pkg::dp_sts_t  sts;

  pchp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pchp_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule
